// ===== rtl/alm_pkg.sv =====
// shared constants, codes and types for the array linked list manager
`timescale 1ns / 1ps

package alm_pkg;

	localparam int CAPACITY = 255;
	localparam int SLOT_W   = 8;
	localparam int DATA_W   = 32;
	localparam int NSLOTS   = CAPACITY + 1;

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_LOCATE = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_POS = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	typedef enum logic [3:0] {
		STEP_IDLE,
		STEP_DECODE,
		STEP_INS_APP,
		STEP_INS_RD,
		STEP_INS_W1,
		STEP_INS_W2,
		STEP_DEL_RD,
		STEP_DEL_UL,
		STEP_DEL_RD2,
		STEP_DEL_MV1,
		STEP_DEL_MV2,
		STEP_WALK,
		STEP_WALK_WAIT,
		STEP_DONE
	} step_t;

	typedef struct packed {
		step_t step;
		logic  accept;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic [1:0] err;
		logic [1:0] func;
		logic       is_append;
		logic       is_last;
		logic       walk_done;
	} stat_t;

endpackage

// ===== rtl/array_linked_list_manager.sv =====
// top level of the array linked list manager
`timescale 1ns / 1ps

// Doubly linked list of up to 255 entries kept in slot memories, live entries
// packed in slots 1..count. One operation is worked at a time through a single
// read port and one write port per memory. Locate reads one next link per step
// of the walk, and needs no walk when position equals count since the answer is
// the first free slot. A new beat is taken while the previous result still
// waits in the output register. Unwritten slot memory content never reaches a
// result.
module array_linked_list_manager (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  func,
	input  logic [alm_pkg::SLOT_W-1:0]  position,
	input  logic [alm_pkg::DATA_W-1:0]  element,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [alm_pkg::DATA_W-1:0]  data_out,
	output logic [alm_pkg::SLOT_W-1:0]  slot,
	output logic [alm_pkg::SLOT_W-1:0]  count
);

	alm_pkg::cmd_t  cmd;
	alm_pkg::stat_t stat;

	// sequencer
	alm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// memories and registers
	alm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.func     (func),
		.position (position),
		.element  (element),
		.status   (status),
		.data_out (data_out),
		.slot     (slot),
		.count    (count)
	);

endmodule

// ===== rtl/alm_ctrl.sv =====
// sequencing state machine for the list operations
`timescale 1ns / 1ps

module alm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  alm_pkg::stat_t  stat,
	output alm_pkg::cmd_t   cmd
);

	alm_pkg::step_t state_q, state_d;
	logic           out_valid_q;

	// state and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= alm_pkg::STEP_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_stall  = (state_q != alm_pkg::STEP_IDLE);

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.step     = state_q;
		cmd.accept   = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			alm_pkg::STEP_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = alm_pkg::STEP_DECODE;
				end
			end
			alm_pkg::STEP_DECODE: begin
				if (stat.err != alm_pkg::ST_OK)
					state_d = alm_pkg::STEP_DONE;
				else if (stat.func == alm_pkg::FUNC_INSERT)
					state_d = stat.is_append ? alm_pkg::STEP_INS_APP : alm_pkg::STEP_INS_RD;
				else if (stat.func == alm_pkg::FUNC_DELETE)
					state_d = alm_pkg::STEP_DEL_RD;
				else
					state_d = stat.is_last ? alm_pkg::STEP_DONE : alm_pkg::STEP_WALK;
			end
			alm_pkg::STEP_INS_APP:   state_d = alm_pkg::STEP_DONE;
			alm_pkg::STEP_INS_RD:    state_d = alm_pkg::STEP_INS_W1;
			alm_pkg::STEP_INS_W1:    state_d = alm_pkg::STEP_INS_W2;
			alm_pkg::STEP_INS_W2:    state_d = alm_pkg::STEP_DONE;
			alm_pkg::STEP_DEL_RD:    state_d = alm_pkg::STEP_DEL_UL;
			alm_pkg::STEP_DEL_UL: begin
				state_d = stat.is_last ? alm_pkg::STEP_DONE : alm_pkg::STEP_DEL_RD2;
			end
			alm_pkg::STEP_DEL_RD2:   state_d = alm_pkg::STEP_DEL_MV1;
			alm_pkg::STEP_DEL_MV1:   state_d = alm_pkg::STEP_DEL_MV2;
			alm_pkg::STEP_DEL_MV2:   state_d = alm_pkg::STEP_DONE;
			alm_pkg::STEP_WALK: begin
				state_d = stat.walk_done ? alm_pkg::STEP_DONE : alm_pkg::STEP_WALK_WAIT;
			end
			alm_pkg::STEP_WALK_WAIT: state_d = alm_pkg::STEP_WALK;
			alm_pkg::STEP_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = alm_pkg::STEP_IDLE;
				end
			end
			default: state_d = alm_pkg::STEP_IDLE;
		endcase
	end

endmodule

// ===== rtl/alm_dp.sv =====
// slot memories, list registers and result registers
`timescale 1ns / 1ps

module alm_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  alm_pkg::cmd_t               cmd,
	output alm_pkg::stat_t              stat,
	input  logic [1:0]                  func,
	input  logic [alm_pkg::SLOT_W-1:0]  position,
	input  logic [alm_pkg::DATA_W-1:0]  element,
	output logic [1:0]                  status,
	output logic [alm_pkg::DATA_W-1:0]  data_out,
	output logic [alm_pkg::SLOT_W-1:0]  slot,
	output logic [alm_pkg::SLOT_W-1:0]  count
);

	localparam int SW = alm_pkg::SLOT_W;
	localparam int DW = alm_pkg::DATA_W;

	logic [DW-1:0] elm_mem [alm_pkg::NSLOTS];
	logic [SW-1:0] nxt_mem [alm_pkg::NSLOTS];
	logic [SW-1:0] prv_mem [alm_pkg::NSLOTS];

	logic [DW-1:0] elm_rd_q;
	logic [SW-1:0] nxt_rd_q, prv_rd_q;

	logic [1:0]    func_q;
	logic [SW-1:0] pos_q;
	logic [DW-1:0] elem_q;
	logic [SW-1:0] head_q, tail_q, cnt_q;
	logic [SW-1:0] s_q, i_q;
	logic [DW-1:0] taken_q;
	logic [1:0]    status_q;
	logic [DW-1:0] data_out_q;
	logic [SW-1:0] slot_q, count_q;

	logic          full;
	logic [SW-1:0] ff;
	logic [SW:0]   cnt_p1;
	logic [1:0]    err;

	logic          rd_en;
	logic [SW-1:0] rd_addr;
	logic          elm_we, nxt_we, prv_we;
	logic [SW-1:0] elm_wa, nxt_wa, prv_wa;
	logic [DW-1:0] elm_wd;
	logic [SW-1:0] nxt_wd, prv_wd;

	// operation checks; the free slots always run in order from count+1
	assign full   = (cnt_q == SW'(alm_pkg::CAPACITY));
	assign cnt_p1 = {1'b0, cnt_q} + 1'b1;
	assign ff     = full ? '0 : cnt_p1[SW-1:0];

	always_comb begin
		err = alm_pkg::ST_OK;
		case (func_q)
			alm_pkg::FUNC_INSERT: begin
				if (full)
					err = alm_pkg::ST_FULL;
				else if (pos_q == '0 || {1'b0, pos_q} > cnt_p1)
					err = alm_pkg::ST_BAD_POS;
			end
			alm_pkg::FUNC_DELETE: begin
				if (pos_q == '0 || pos_q > cnt_q)
					err = alm_pkg::ST_BAD_POS;
			end
			alm_pkg::FUNC_LOCATE: begin
				if (pos_q > cnt_q)
					err = alm_pkg::ST_BAD_POS;
			end
			default: err = alm_pkg::ST_BAD_POS;
		endcase
	end

	assign stat.err       = err;
	assign stat.func      = func_q;
	assign stat.is_append = (pos_q == ff);
	assign stat.is_last   = (pos_q == cnt_q);
	assign stat.walk_done = (i_q == pos_q);

	// memory port controls for each step
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pos_q;
		elm_we  = 1'b0;
		nxt_we  = 1'b0;
		prv_we  = 1'b0;
		elm_wa  = ff;
		nxt_wa  = tail_q;
		prv_wa  = ff;
		elm_wd  = elem_q;
		nxt_wd  = ff;
		prv_wd  = tail_q;
		case (cmd.step)
			alm_pkg::STEP_INS_APP: begin
				elm_we = 1'b1;
				nxt_we = (cnt_q != '0);
				prv_we = (cnt_q != '0);
			end
			alm_pkg::STEP_INS_RD, alm_pkg::STEP_DEL_RD: begin
				rd_en = 1'b1;
			end
			alm_pkg::STEP_INS_W1: begin
				elm_we = 1'b1;
				prv_we = 1'b1;
				prv_wd = prv_rd_q;
				nxt_we = 1'b1;
				nxt_wa = ff;
				nxt_wd = pos_q;
			end
			alm_pkg::STEP_INS_W2: begin
				prv_we = 1'b1;
				prv_wa = pos_q;
				prv_wd = ff;
				nxt_we = (pos_q != head_q);
				nxt_wa = prv_rd_q;
				nxt_wd = ff;
			end
			alm_pkg::STEP_DEL_UL: begin
				nxt_we = (pos_q != head_q);
				nxt_wa = prv_rd_q;
				nxt_wd = nxt_rd_q;
				prv_we = (pos_q != tail_q);
				prv_wa = nxt_rd_q;
				prv_wd = prv_rd_q;
			end
			alm_pkg::STEP_DEL_RD2: begin
				rd_en   = 1'b1;
				rd_addr = cnt_q;
			end
			alm_pkg::STEP_DEL_MV1: begin
				elm_we = 1'b1;
				elm_wa = pos_q;
				elm_wd = elm_rd_q;
				nxt_we = 1'b1;
				nxt_wa = pos_q;
				nxt_wd = nxt_rd_q;
				prv_we = 1'b1;
				prv_wa = pos_q;
				prv_wd = prv_rd_q;
			end
			alm_pkg::STEP_DEL_MV2: begin
				nxt_we = (cnt_q != head_q);
				nxt_wa = prv_rd_q;
				nxt_wd = pos_q;
				prv_we = (cnt_q != tail_q);
				prv_wa = nxt_rd_q;
				prv_wd = pos_q;
			end
			alm_pkg::STEP_WALK: begin
				rd_en   = (i_q != pos_q);
				rd_addr = s_q;
			end
			default: ;
		endcase
	end

	// slot memories with registered read
	always_ff @(posedge clk) begin
		if (elm_we)
			elm_mem[elm_wa] <= elm_wd;
		if (nxt_we)
			nxt_mem[nxt_wa] <= nxt_wd;
		if (prv_we)
			prv_mem[prv_wa] <= prv_wd;
		if (rd_en) begin
			elm_rd_q <= elm_mem[rd_addr];
			nxt_rd_q <= nxt_mem[rd_addr];
			prv_rd_q <= prv_mem[rd_addr];
		end
	end

	// list control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= SW'(1);
			tail_q <= '0;
			cnt_q  <= '0;
		end else begin
			case (cmd.step)
				alm_pkg::STEP_INS_APP: begin
					if (cnt_q == '0)
						head_q <= ff;
					tail_q <= ff;
				end
				alm_pkg::STEP_INS_W2: begin
					if (pos_q == head_q)
						head_q <= ff;
				end
				alm_pkg::STEP_DEL_UL: begin
					if (pos_q == head_q)
						head_q <= nxt_rd_q;
					if (pos_q == tail_q)
						tail_q <= prv_rd_q;
				end
				alm_pkg::STEP_DEL_MV2: begin
					if (cnt_q == head_q)
						head_q <= pos_q;
					if (cnt_q == tail_q)
						tail_q <= pos_q;
				end
				alm_pkg::STEP_DONE: begin
					if (cmd.load_out && err == alm_pkg::ST_OK) begin
						if (func_q == alm_pkg::FUNC_INSERT)
							cnt_q <= cnt_q + 1'b1;
						else if (func_q == alm_pkg::FUNC_DELETE)
							cnt_q <= cnt_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// operand, walk and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
			pos_q  <= position;
			elem_q <= element;
		end
		case (cmd.step)
			alm_pkg::STEP_DECODE: begin
				s_q <= head_q;
				i_q <= '0;
			end
			alm_pkg::STEP_WALK_WAIT: begin
				s_q <= nxt_rd_q;
				i_q <= i_q + 1'b1;
			end
			alm_pkg::STEP_DEL_UL: taken_q <= elm_rd_q;
			default: ;
		endcase
		if (cmd.load_out) begin
			status_q   <= err;
			data_out_q <= '0;
			slot_q     <= '0;
			count_q    <= cnt_q;
			if (err == alm_pkg::ST_OK) begin
				if (func_q == alm_pkg::FUNC_DELETE) begin
					data_out_q <= taken_q;
					count_q    <= cnt_q - 1'b1;
				end else if (func_q == alm_pkg::FUNC_INSERT) begin
					count_q <= cnt_q + 1'b1;
				end else begin
					slot_q <= (pos_q == cnt_q) ? ff : s_q;
				end
			end
		end
	end

	assign status   = status_q;
	assign data_out = data_out_q;
	assign slot     = slot_q;
	assign count    = count_q;

endmodule
